[hw/rtl/uaec_pkg.sv]
package uaec_pkg;

  localparam logic [7:0] CTRL_RESET_VALUE = 8'h1F;
  localparam logic [7:0] ESD_RESET_VALUE  = 8'h01;
  localparam logic [4:0] ADC_CARKIT_ONE   = 5'h17;
  localparam logic [4:0] ADC_CARKIT_TWO   = 5'h1B;

  localparam logic OP_SERVICE = 1'b0;
  localparam logic OP_INIT    = 1'b1;

  localparam logic [2:0] ACT_NONE         = 3'd0;
  localparam logic [2:0] ACT_ATTACHED     = 3'd1;
  localparam logic [2:0] ACT_DETACHED     = 3'd2;
  localparam logic [2:0] ACT_ATTACH_EMPTY = 3'd3;
  localparam logic [2:0] ACT_DETACH_EMPTY = 3'd4;

  localparam logic [1:0] VB_NONE = 2'd0;
  localparam logic [1:0] VB_IN   = 2'd1;
  localparam logic [1:0] VB_OUT  = 2'd2;

  localparam logic [4:0] CBL_NONE         = 5'd0;
  localparam logic [4:0] CBL_OTG          = 5'd1;
  localparam logic [4:0] CBL_DCP          = 5'd2;
  localparam logic [4:0] CBL_CDP          = 5'd3;
  localparam logic [4:0] CBL_CARKIT_ONE   = 5'd4;
  localparam logic [4:0] CBL_CARKIT_TWO   = 5'd5;
  localparam logic [4:0] CBL_UART         = 5'd6;
  localparam logic [4:0] CBL_USB          = 5'd7;
  localparam logic [4:0] CBL_AV           = 5'd8;
  localparam logic [4:0] CBL_TTY          = 5'd9;
  localparam logic [4:0] CBL_PPD          = 5'd10;
  localparam logic [4:0] CBL_JIG_UART_OFF = 5'd11;
  localparam logic [4:0] CBL_JIG_UART_ON  = 5'd12;
  localparam logic [4:0] CBL_JIG_USB_OFF  = 5'd13;
  localparam logic [4:0] CBL_JIG_USB_ON   = 5'd14;
  localparam logic [4:0] CBL_U200         = 5'd15;
  localparam logic [4:0] CBL_APPLE        = 5'd16;
  localparam logic [4:0] CBL_UNKNOWN_VBUS = 5'd17;
  localparam logic [4:0] CBL_MHL          = 5'd18;

  typedef struct packed {
    logic       operation;
    logic [7:0] control_readback;
    logic [7:0] reset_readback;
    logic [7:0] irq_status_one;
    logic [7:0] irq_status_two;
    logic [7:0] device_type_one;
    logic [7:0] device_type_two;
    logic [7:0] device_type_three;
    logic [4:0] adc_code;
  } event_t;

  typedef struct packed {
    logic       reinit_request;
    logic [2:0] cable_action;
    logic [4:0] cable_code;
    logic [1:0] vbus_event;
  } result_t;

endpackage

[hw/rtl/uaec_decode.sv]
module uaec_decode (
  input  uaec_pkg::event_t  ev,
  input  logic [4:0]        previous_cable,
  output uaec_pkg::result_t res,
  output logic              cable_store,
  output logic [4:0]        cable_new
);

  function automatic logic [4:0] classify(input logic [7:0] d1, input logic [7:0] d2,
                                          input logic [7:0] d3, input logic [4:0] adc);
    logic [4:0] c;
    c = uaec_pkg::CBL_NONE;
    if (d1[7])             c = uaec_pkg::CBL_OTG;
    else if (d1[6])        c = uaec_pkg::CBL_DCP;
    else if (d1[5])        c = uaec_pkg::CBL_CDP;
    else if (d1[4]) begin
      if (adc == uaec_pkg::ADC_CARKIT_ONE)      c = uaec_pkg::CBL_CARKIT_ONE;
      else if (adc == uaec_pkg::ADC_CARKIT_TWO) c = uaec_pkg::CBL_CARKIT_TWO;
      else                                      c = uaec_pkg::CBL_NONE;
    end
    else if (d1[3])        c = uaec_pkg::CBL_UART;
    else if (d1[2])        c = uaec_pkg::CBL_USB;
    else if (|d1[1:0])     c = uaec_pkg::CBL_NONE;
    else if (d2[6])        c = uaec_pkg::CBL_AV;
    else if (d2[5])        c = uaec_pkg::CBL_TTY;
    else if (d2[4])        c = uaec_pkg::CBL_PPD;
    else if (d2[3])        c = uaec_pkg::CBL_JIG_UART_OFF;
    else if (d2[2])        c = uaec_pkg::CBL_JIG_UART_ON;
    else if (d2[1])        c = uaec_pkg::CBL_JIG_USB_OFF;
    else if (d2[0])        c = uaec_pkg::CBL_JIG_USB_ON;
    else if (d3[7])        c = uaec_pkg::CBL_NONE;
    else if (d3[6])        c = uaec_pkg::CBL_U200;
    else if (d3[5])        c = uaec_pkg::CBL_APPLE;
    else if (d3[4])        c = uaec_pkg::CBL_NONE;
    else if (|d3[2:1])     c = uaec_pkg::CBL_UNKNOWN_VBUS;
    else if (d3[0])        c = uaec_pkg::CBL_MHL;
    return c;
  endfunction

  logic       attach;
  logic [4:0] cable;

  assign cable = classify(ev.device_type_one, ev.device_type_two,
                          ev.device_type_three, ev.adc_code);

  always_comb begin
    res = '0;
    res.cable_action = uaec_pkg::ACT_NONE;
    res.cable_code   = uaec_pkg::CBL_NONE;
    res.vbus_event   = uaec_pkg::VB_NONE;
    attach = 1'b0;
    if (ev.operation == uaec_pkg::OP_INIT) begin
      attach = 1'b1;
    end else begin
      res.reinit_request = (ev.control_readback == uaec_pkg::CTRL_RESET_VALUE) ||
                           (ev.reset_readback == uaec_pkg::ESD_RESET_VALUE);
      if (ev.irq_status_one[1]) begin
        if (previous_cable == uaec_pkg::CBL_NONE) begin
          res.cable_action = uaec_pkg::ACT_DETACH_EMPTY;
        end else begin
          res.cable_action = uaec_pkg::ACT_DETACHED;
          res.cable_code   = previous_cable;
        end
      end else if (ev.irq_status_one[0] || ev.irq_status_two[1]) begin
        attach = 1'b1;
      end else if (ev.irq_status_two[0]) begin
        res.vbus_event = uaec_pkg::VB_IN;
      end else if (ev.irq_status_two[7]) begin
        res.vbus_event = uaec_pkg::VB_OUT;
      end
    end
    if (attach) begin
      if (ev.device_type_three[1]) res.vbus_event = uaec_pkg::VB_IN;
      if (cable == uaec_pkg::CBL_NONE) begin
        res.cable_action = uaec_pkg::ACT_ATTACH_EMPTY;
      end else begin
        res.cable_action = uaec_pkg::ACT_ATTACHED;
        res.cable_code   = cable;
      end
    end
  end

  assign cable_store = attach && (cable != uaec_pkg::CBL_NONE);
  assign cable_new   = cable;

endmodule

[hw/rtl/usb_accessory_event_classifier.sv]
// Datapath: an accepted input goes to the input register, then to the result register,
// where it is valid; it moves on only when the result register is empty or being read.
// Throughput: one item per cycle unless out_ready stalls it; the remembered cable updates
// as an item moves to the result register, so the next item sees it without a bubble.
// Reset: synchronous, active high; clears both valid flags and the remembered cable
// (no cable).
module usb_accessory_event_classifier (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       operation,
  input  logic [7:0] control_readback,
  input  logic [7:0] reset_readback,
  input  logic [7:0] irq_status_one,
  input  logic [7:0] irq_status_two,
  input  logic [7:0] device_type_one,
  input  logic [7:0] device_type_two,
  input  logic [7:0] device_type_three,
  input  logic [4:0] adc_code,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       reinit_request,
  output logic [2:0] cable_action,
  output logic [4:0] cable_code,
  output logic [1:0] vbus_event
);

  uaec_pkg::event_t  ev;
  uaec_pkg::result_t res;
  uaec_pkg::result_t res_next;
  logic              ev_valid;
  logic [4:0]        previous_cable;
  logic              cable_store;
  logic [4:0]        cable_new;
  logic              advance;

  assign advance  = ev_valid && (!out_valid || out_ready);
  assign in_ready = !ev_valid || advance;

  uaec_decode u_decode (
    .ev             (ev),
    .previous_cable (previous_cable),
    .res            (res_next),
    .cable_store    (cable_store),
    .cable_new      (cable_new)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      ev_valid       <= 1'b0;
      out_valid      <= 1'b0;
      previous_cable <= uaec_pkg::CBL_NONE;
    end else begin
      if (in_ready) ev_valid <= in_valid;
      if (advance) begin
        out_valid <= 1'b1;
        if (cable_store) previous_cable <= cable_new;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      ev.operation         <= operation;
      ev.control_readback  <= control_readback;
      ev.reset_readback    <= reset_readback;
      ev.irq_status_one    <= irq_status_one;
      ev.irq_status_two    <= irq_status_two;
      ev.device_type_one   <= device_type_one;
      ev.device_type_two   <= device_type_two;
      ev.device_type_three <= device_type_three;
      ev.adc_code          <= adc_code;
    end
    if (advance) res <= res_next;
  end

  assign reinit_request = res.reinit_request;
  assign cable_action   = res.cable_action;
  assign cable_code     = res.cable_code;
  assign vbus_event     = res.vbus_event;

endmodule

[sim/usb_accessory_event_classifier_tb.sv]
module usb_accessory_event_classifier_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_ITEMS = 1800;
  localparam int CYCLE_LIMIT  = 100000;
  localparam int HOLD_AT      = 600;
  localparam int HOLD_CYCLES  = 160;
  localparam int CALM_FROM    = 1000;
  localparam int CALM_TO      = 1300;
  localparam int DRAIN_CYCLES = 10;

  logic              clk       = 1'b0;
  logic              rst       = 1'b1;
  logic              in_valid  = 1'b0;
  logic              out_ready = 1'b0;
  uaec_pkg::event_t  offer     = '0;
  logic              in_ready;
  logic              out_valid;
  logic              reinit_request;
  logic [2:0]        cable_action;
  logic [4:0]        cable_code;
  logic [1:0]        vbus_event;

  uaec_pkg::event_t  pending_events[$];
  uaec_pkg::result_t expected_results[$];
  logic [4:0]        last_cable = uaec_pkg::CBL_NONE;
  int                accepted_cnt = 0;
  int                cycle_cnt = 0;
  int                error_cnt = 0;
  int                hold_left = 0;
  bit                hold_done = 1'b0;

  usb_accessory_event_classifier dut (
    .clk               (clk),
    .rst               (rst),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .operation         (offer.operation),
    .control_readback  (offer.control_readback),
    .reset_readback    (offer.reset_readback),
    .irq_status_one    (offer.irq_status_one),
    .irq_status_two    (offer.irq_status_two),
    .device_type_one   (offer.device_type_one),
    .device_type_two   (offer.device_type_two),
    .device_type_three (offer.device_type_three),
    .adc_code          (offer.adc_code),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .reinit_request    (reinit_request),
    .cable_action      (cable_action),
    .cable_code        (cable_code),
    .vbus_event        (vbus_event)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  function automatic logic [4:0] classify_cable(input logic [7:0] t1, input logic [7:0] t2,
                                                input logic [7:0] t3, input logic [4:0] adc);
    if (t1[7]) return uaec_pkg::CBL_OTG;
    if (t1[6]) return uaec_pkg::CBL_DCP;
    if (t1[5]) return uaec_pkg::CBL_CDP;
    if (t1[4]) begin
      if (adc == uaec_pkg::ADC_CARKIT_ONE) return uaec_pkg::CBL_CARKIT_ONE;
      if (adc == uaec_pkg::ADC_CARKIT_TWO) return uaec_pkg::CBL_CARKIT_TWO;
      return uaec_pkg::CBL_NONE;
    end
    if (t1[3]) return uaec_pkg::CBL_UART;
    if (t1[2]) return uaec_pkg::CBL_USB;
    if (t1[1:0] != 2'b00) return uaec_pkg::CBL_NONE;
    if (t2[6]) return uaec_pkg::CBL_AV;
    if (t2[5]) return uaec_pkg::CBL_TTY;
    if (t2[4]) return uaec_pkg::CBL_PPD;
    if (t2[3]) return uaec_pkg::CBL_JIG_UART_OFF;
    if (t2[2]) return uaec_pkg::CBL_JIG_UART_ON;
    if (t2[1]) return uaec_pkg::CBL_JIG_USB_OFF;
    if (t2[0]) return uaec_pkg::CBL_JIG_USB_ON;
    if (t3[7]) return uaec_pkg::CBL_NONE;
    if (t3[6]) return uaec_pkg::CBL_U200;
    if (t3[5]) return uaec_pkg::CBL_APPLE;
    if (t3[4]) return uaec_pkg::CBL_NONE;
    if (t3[2:1] != 2'b00) return uaec_pkg::CBL_UNKNOWN_VBUS;
    if (t3[0]) return uaec_pkg::CBL_MHL;
    return uaec_pkg::CBL_NONE;
  endfunction

  function automatic uaec_pkg::result_t predict_outcome(input uaec_pkg::event_t ev);
    uaec_pkg::result_t r;
    logic              attach;
    logic [4:0]        found;
    r                = '0;
    r.cable_action   = uaec_pkg::ACT_NONE;
    r.cable_code     = uaec_pkg::CBL_NONE;
    r.vbus_event     = uaec_pkg::VB_NONE;
    attach           = (ev.operation == uaec_pkg::OP_INIT);
    if (!attach) begin
      r.reinit_request = (ev.control_readback == uaec_pkg::CTRL_RESET_VALUE) ||
                         (ev.reset_readback == uaec_pkg::ESD_RESET_VALUE);
      if (ev.irq_status_one[1]) begin
        if (last_cable == uaec_pkg::CBL_NONE) begin
          r.cable_action = uaec_pkg::ACT_DETACH_EMPTY;
        end else begin
          r.cable_action = uaec_pkg::ACT_DETACHED;
          r.cable_code   = last_cable;
        end
      end else if (ev.irq_status_one[0] || ev.irq_status_two[1]) begin
        attach = 1'b1;
      end else if (ev.irq_status_two[0]) begin
        r.vbus_event = uaec_pkg::VB_IN;
      end else if (ev.irq_status_two[7]) begin
        r.vbus_event = uaec_pkg::VB_OUT;
      end
    end
    if (attach) begin
      found = classify_cable(ev.device_type_one, ev.device_type_two, ev.device_type_three,
                             ev.adc_code);
      if (ev.device_type_three[1]) r.vbus_event = uaec_pkg::VB_IN;
      if (found == uaec_pkg::CBL_NONE) begin
        r.cable_action = uaec_pkg::ACT_ATTACH_EMPTY;
      end else begin
        r.cable_action = uaec_pkg::ACT_ATTACHED;
        r.cable_code   = found;
        last_cable     = found;
      end
    end
    return r;
  endfunction

  function automatic uaec_pkg::event_t random_event();
    uaec_pkg::event_t ev;
    logic [23:0]      dev;
    int               pos;
    ev.operation         = ($urandom_range(9) == 0) ? uaec_pkg::OP_INIT
                                                    : uaec_pkg::OP_SERVICE;
    ev.control_readback  = ($urandom_range(9) == 0) ? uaec_pkg::CTRL_RESET_VALUE
                                                    : 8'($urandom);
    ev.reset_readback    = ($urandom_range(9) == 0) ? uaec_pkg::ESD_RESET_VALUE
                                                    : 8'($urandom);
    ev.irq_status_one    = 8'($urandom);
    ev.irq_status_two    = 8'($urandom);
    case ($urandom_range(15))
      0, 1, 2: ev.irq_status_one[1] = 1'b1;
      3, 4, 5: ev.irq_status_one[1:0] = 2'b01;
      6, 7: begin
        ev.irq_status_one[1:0] = 2'b00;
        ev.irq_status_two[1]   = 1'b1;
      end
      8, 9, 10: begin
        ev.irq_status_one[1:0] = 2'b00;
        ev.irq_status_two[1:0] = 2'b01;
      end
      11, 12: begin
        ev.irq_status_one[1:0] = 2'b00;
        ev.irq_status_two[1:0] = 2'b00;
        ev.irq_status_two[7]   = 1'b1;
      end
      13: begin
        ev.irq_status_one[1:0] = 2'b00;
        ev.irq_status_two      = ev.irq_status_two & 8'h7C;
      end
      default: ;
    endcase
    // pick the deciding device-type bit, clear everything ahead of it in the chain
    dev = 24'($urandom);
    if ($urandom_range(9) != 0) begin
      pos = $urandom_range(23);
      dev = (dev & 24'((25'd1 << (pos + 1)) - 25'd1)) | (24'd1 << pos);
    end
    {ev.device_type_one, ev.device_type_two, ev.device_type_three} = dev;
    case ($urandom_range(9))
      0, 1, 2: ev.adc_code = uaec_pkg::ADC_CARKIT_ONE;
      3, 4, 5: ev.adc_code = uaec_pkg::ADC_CARKIT_TWO;
      default: ev.adc_code = 5'($urandom);
    endcase
    return ev;
  endfunction

  function automatic bit idle_now();
    if (accepted_cnt >= CALM_FROM && accepted_cnt < CALM_TO) return 1'b0;
    return $urandom_range(99) < 36;
  endfunction

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
  end

  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (!hold_done && accepted_cnt >= HOLD_AT) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        expected_results.push_back(predict_outcome(offer));
        accepted_cnt <= accepted_cnt + 1;
      end
      if (!in_valid || in_ready) begin
        if (pending_events.size() != 0 && !idle_now()) begin
          offer    <= pending_events.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : result_monitor
    uaec_pkg::result_t seen;
    uaec_pkg::result_t want;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        seen = '{reinit_request, cable_action, cable_code, vbus_event};
        if (expected_results.size() == 0) begin
          if (error_cnt < 10)
            $display("unexpected result reinit=%0d action=%0d code=%0d vbus=%0d",
                     seen.reinit_request, seen.cable_action, seen.cable_code,
                     seen.vbus_event);
          error_cnt++;
        end else begin
          want = expected_results.pop_front();
          if (seen.reinit_request !== want.reinit_request ||
              seen.cable_action !== want.cable_action ||
              seen.cable_code !== want.cable_code ||
              seen.vbus_event !== want.vbus_event) begin
            if (error_cnt < 10)
              $display("mismatch: reinit %0d/%0d action %0d/%0d code %0d/%0d vbus %0d/%0d",
                       want.reinit_request, seen.reinit_request, want.cable_action,
                       seen.cable_action, want.cable_code, seen.cable_code,
                       want.vbus_event, seen.vbus_event);
            error_cnt++;
          end
        end
      end
      out_ready <= (hold_left == 0) && !idle_now();
    end
  end

  initial begin
    // op, control, reset, irq1, irq2, type1, type2, type3, adc
    pending_events.push_back('{uaec_pkg::OP_SERVICE,
                               8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 5'h00});
    pending_events.push_back('{uaec_pkg::OP_SERVICE,
                               8'h00, 8'h00, 8'h02, 8'h00, 8'h00, 8'h00, 8'h00, 5'h00});
    pending_events.push_back('{uaec_pkg::OP_SERVICE,
                               8'h1F, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 5'h00});
    pending_events.push_back('{uaec_pkg::OP_SERVICE,
                               8'h00, 8'h01, 8'h00, 8'h01, 8'h00, 8'h00, 8'h00, 5'h00});
    pending_events.push_back('{uaec_pkg::OP_SERVICE,
                               8'h00, 8'h00, 8'h00, 8'h80, 8'h00, 8'h00, 8'h00, 5'h00});
    pending_events.push_back('{uaec_pkg::OP_SERVICE,
                               8'h00, 8'h00, 8'h01, 8'h00, 8'h80, 8'h00, 8'h02, 5'h00});
    pending_events.push_back('{uaec_pkg::OP_SERVICE,
                               8'h00, 8'h00, 8'h02, 8'h00, 8'h00, 8'h00, 8'h00, 5'h00});
    pending_events.push_back('{uaec_pkg::OP_SERVICE,
                               8'h00, 8'h00, 8'h00, 8'h02, 8'h10, 8'h00, 8'h00, 5'h17});
    pending_events.push_back('{uaec_pkg::OP_SERVICE,
                               8'h00, 8'h00, 8'h01, 8'h00, 8'h10, 8'h00, 8'h00, 5'h1B});
    pending_events.push_back('{uaec_pkg::OP_SERVICE,
                               8'h00, 8'h00, 8'h01, 8'h00, 8'h10, 8'h00, 8'h00, 5'h05});
    pending_events.push_back('{uaec_pkg::OP_SERVICE,
                               8'h00, 8'h00, 8'h02, 8'h00, 8'h00, 8'h00, 8'h00, 5'h00});
    pending_events.push_back('{uaec_pkg::OP_SERVICE,
                               8'h00, 8'h00, 8'h01, 8'h00, 8'h03, 8'hFF, 8'hFF, 5'h00});
    pending_events.push_back('{uaec_pkg::OP_SERVICE,
                               8'h00, 8'h00, 8'h01, 8'h00, 8'h00, 8'h00, 8'hFF, 5'h00});
    pending_events.push_back('{uaec_pkg::OP_SERVICE,
                               8'h00, 8'h00, 8'h01, 8'h00, 8'h00, 8'h00, 8'h12, 5'h00});
    pending_events.push_back('{uaec_pkg::OP_SERVICE,
                               8'h00, 8'h00, 8'h01, 8'h00, 8'h00, 8'h00, 8'h04, 5'h00});
    pending_events.push_back('{uaec_pkg::OP_SERVICE,
                               8'h00, 8'h00, 8'h01, 8'h00, 8'h00, 8'h00, 8'h01, 5'h00});
    pending_events.push_back('{uaec_pkg::OP_INIT,
                               8'h1F, 8'h01, 8'hFF, 8'hFF, 8'h00, 8'h01, 8'h00, 5'h00});
    pending_events.push_back('{uaec_pkg::OP_INIT,
                               8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 5'h00});
    pending_events.push_back('{uaec_pkg::OP_SERVICE,
                               8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 5'h1F});
    pending_events.push_back('{uaec_pkg::OP_INIT,
                               8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 5'h1F});
    pending_events.push_back('{uaec_pkg::OP_SERVICE,
                               8'h00, 8'h00, 8'h01, 8'h00, 8'h00, 8'h40, 8'h00, 5'h1F});
    pending_events.push_back('{uaec_pkg::OP_SERVICE,
                               8'h00, 8'h00, 8'h01, 8'h00, 8'h10, 8'h00, 8'h00, 5'h1F});
    pending_events.push_back('{uaec_pkg::OP_SERVICE,
                               8'h00, 8'h00, 8'h00, 8'h81, 8'h00, 8'h00, 8'h00, 5'h00});
    repeat (RANDOM_ITEMS) pending_events.push_back(random_event());

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    while ((pending_events.size() != 0 || in_valid || expected_results.size() != 0) &&
           cycle_cnt < CYCLE_LIMIT)
      @(negedge clk);

    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("usb_accessory_event_classifier_tb: errors");
      $finish;
    end else begin
      repeat (DRAIN_CYCLES) @(negedge clk);
      if (error_cnt == 0 && expected_results.size() == 0) begin
        $display("usb_accessory_event_classifier_tb: clean");
      end else begin
        $display("usb_accessory_event_classifier_tb: errors");
      end
      $finish;
    end
  end

endmodule

[sim.f]
hw/rtl/uaec_pkg.sv
hw/rtl/uaec_decode.sv
hw/rtl/usb_accessory_event_classifier.sv
sim/usb_accessory_event_classifier_tb.sv
